### src/erw_pkg.sv
// ----------------------------------------------------------------------------
// erw_pkg
// Types and constants shared by the ellipse residual and weight core.
// ----------------------------------------------------------------------------
`default_nettype none

package erw_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int WEIGHT_FRAC_BITS = 15;
   localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + 1;
   localparam int RESIDUAL_WIDTH   = 24;
   localparam int RADIUS_WIDTH     = 15;
   localparam int ROTATION_WIDTH   = 32;
   localparam int TRIG_WIDTH       = 16;
   localparam int THRESH_WIDTH     = 23;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic [RADIUS_WIDTH-1:0]   RADIUS_RESET   = RADIUS_WIDTH'(16);
   localparam logic [ROTATION_WIDTH-1:0] ROTATION_RESET = ROTATION_WIDTH'(16384);

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(1) << WEIGHT_FRAC_BITS;
   localparam logic [RESIDUAL_WIDTH-1:0] RES_MAG_NEG =
      RESIDUAL_WIDTH'(1) << (RESIDUAL_WIDTH - 1);
   localparam logic [RESIDUAL_WIDTH-1:0] RES_MAX_POS = RES_MAG_NEG - RESIDUAL_WIDTH'(1);

   typedef enum logic [2:0] {
      CSR_CENTER_X       = 3'd0,
      CSR_CENTER_Y       = 3'd1,
      CSR_RADIUS_MAJOR   = 3'd2,
      CSR_RADIUS_MINOR   = 3'd3,
      CSR_ROTATION       = 3'd4,
      CSR_LOSS_MODE      = 3'd5,
      CSR_LOSS_THRESHOLD = 3'd6,
      CSR_MIN_WEIGHT     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      LOSS_NONE  = 2'd0,
      LOSS_HUBER = 2'd1,
      LOSS_TUKEY = 2'd2
   } loss_mode_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [RESIDUAL_WIDTH-1:0] residual;
      logic [WEIGHT_WIDTH-1:0]          weight;
   } rsp_payload_type;

endpackage

`default_nettype wire

### src/erw_div.sv
// ----------------------------------------------------------------------------
// erw_div
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_div #(
   parameter int NUM_W  = 79,
   parameter int DEN_W  = 56,
   parameter int QUO_W  = 24,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quotient,
   output logic [SIDE_W-1:0] side_out
);
   localparam int EXT_W = DEN_W + QUO_W;

   logic              valid_ff [QUO_W];
   logic [EXT_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int SHIFT = QUO_W - 1 - k;
      logic              valid_cur;
      logic [EXT_W-1:0]  rem_cur;
      logic [QUO_W-1:0]  quo_cur;
      logic [DEN_W-1:0]  den_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [EXT_W-1:0]  trial;
      logic              take;
      logic [EXT_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_head
         assign valid_cur = in_valid;
         assign rem_cur   = EXT_W'(num);
         assign quo_cur   = '0;
         assign den_cur   = den;
         assign side_cur  = side_in;
      end else begin : g_body
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign quo_cur   = quo_ff[k-1];
         assign den_cur   = den_ff[k-1];
         assign side_cur  = side_ff[k-1];
      end

      assign trial  = EXT_W'(den_cur) << SHIFT;
      assign take   = rem_cur >= trial;
      assign rem_in = take ? rem_cur - trial : rem_cur;
      assign quo_in = take ? (quo_cur | (QUO_W'(1) << SHIFT)) : quo_cur;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quotient  = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

### src/erw_sqrt.sv
// ----------------------------------------------------------------------------
// erw_sqrt
// Pipelined integer square root, one root bit per stage, side data alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_sqrt #(
   parameter int RAD_W  = 109,
   parameter int ROOT_W = 55,
   parameter int SIDE_W = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  radicand,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root,
   output logic [SIDE_W-1:0] side_out
);
   localparam int EXT_W = 2 * ROOT_W + 1;

   logic              valid_ff [ROOT_W];
   logic [EXT_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - k;
      logic              valid_cur;
      logic [EXT_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [EXT_W-1:0]  trial;
      logic              take;
      logic [EXT_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_head
         assign valid_cur = in_valid;
         assign rem_cur   = EXT_W'(radicand);
         assign root_cur  = '0;
         assign side_cur  = side_in;
      end else begin : g_body
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign root_cur  = root_ff[k-1];
         assign side_cur  = side_ff[k-1];
      end

      assign trial   = (EXT_W'(root_cur) << (BIT + 1)) | (EXT_W'(1) << (2 * BIT));
      assign take    = rem_cur >= trial;
      assign rem_in  = take ? rem_cur - trial : rem_cur;
      assign root_in = take ? (root_cur | (ROOT_W'(1) << BIT)) : root_cur;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

### src/ellipse_residual_weight_core.sv
// ----------------------------------------------------------------------------
// ellipse_residual_weight_core
// Geometric residual of an edge point against a configured ellipse, with a
// robust weight (none, Huber or Tukey) floored at a minimum weight.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  req_     | in        | one edge point (point_x, point_y)
//  rsp_     | out       | residual and weight of that point
//  csr_     | in        | register index and write data
//
//  One point per cycle while no result is held on rsp_.
//  The pipeline holds the 55-stage square root and the 24- and 16-stage
//  dividers of the residual and the weight.
//  Reset clears all valid bits and loads the register reset values.
//  A result held on rsp_ halts every stage together and drops req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_residual_weight_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  erw_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output erw_pkg::rsp_payload_type rsp_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  erw_pkg::csr_index_type  csr_index,
   input  logic [erw_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import erw_pkg::*;

   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int PROD_W   = DIFF_W + TRIG_WIDTH;
   localparam int SUM_W    = PROD_W + 1;
   localparam int RND_SH   = 10;
   localparam int LOC_W    = SUM_W - RND_SH;
   localparam int LOC2_W   = 2 * LOC_W;
   localparam int RAD2_W   = 2 * RADIUS_WIDTH;
   localparam int RAD4_W   = 2 * RAD2_W;
   localparam int PART_W   = LOC_W + RAD2_W;
   localparam int P_W      = LOC2_W + RAD2_W + 1;
   localparam int Q_SH     = 8;
   localparam int RX_W     = LOC2_W + RAD4_W;
   localparam int R_W      = RX_W + 1;
   localparam int ROOT_W   = (R_W + 1) / 2;
   localparam int DVD_W    = ROOT_W + 1;
   localparam int QUO_W    = RESIDUAL_WIDTH;
   localparam int OVF_W    = DVD_W + QUO_W;
   localparam int T2_W     = 2 * THRESH_WIDTH;
   localparam int M2_W     = 2 * RESIDUAL_WIDTH;
   localparam int WNUM_W   = T2_W + WEIGHT_FRAC_BITS;
   localparam int WSIDE_W  = RESIDUAL_WIDTH + WEIGHT_WIDTH + 2;
   localparam int UU_W     = 2 * WEIGHT_WIDTH;
   localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SH - 1);

   // configuration
   logic signed [COORD_WIDTH-1:0] cx_ff, cy_ff;
   logic [RADIUS_WIDTH-1:0]       ra_ff, rb_ff;
   logic [ROTATION_WIDTH-1:0]     rot_ff;
   logic [1:0]                    mode_ff;
   logic [THRESH_WIDTH-1:0]       thr_ff;
   logic [WEIGHT_WIDTH-1:0]       minw_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         ra_ff   <= RADIUS_RESET;
         rb_ff   <= RADIUS_RESET;
         rot_ff  <= ROTATION_RESET;
         mode_ff <= LOSS_NONE;
         thr_ff  <= '0;
         minw_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X:       cx_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CENTER_Y:       cy_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_RADIUS_MAJOR:   ra_ff   <= csr_wdata[RADIUS_WIDTH-1:0];
            CSR_RADIUS_MINOR:   rb_ff   <= csr_wdata[RADIUS_WIDTH-1:0];
            CSR_ROTATION:       rot_ff  <= csr_wdata[ROTATION_WIDTH-1:0];
            CSR_LOSS_MODE:      mode_ff <= csr_wdata[1:0];
            CSR_LOSS_THRESHOLD: thr_ff  <= csr_wdata[THRESH_WIDTH-1:0];
            CSR_MIN_WEIGHT:     minw_ff <= csr_wdata[WEIGHT_WIDTH-1:0];
            default:            ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   logic signed [TRIG_WIDTH-1:0] cos_w, sin_w;
   logic [RADIUS_WIDTH-1:0]      a_eff, b_eff;
   assign cos_w = rot_ff[TRIG_WIDTH-1:0];
   assign sin_w = rot_ff[ROTATION_WIDTH-1:TRIG_WIDTH];
   assign a_eff = (ra_ff == '0) ? RADIUS_WIDTH'(1) : ra_ff;
   assign b_eff = (rb_ff == '0) ? RADIUS_WIDTH'(1) : rb_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic v10_ff, v11_ff, v12_ff, v13_ff, v14_ff;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [PROD_W-1:0] pcx_ff, psy_ff, pcy_ff, psx_ff;
   logic signed [SUM_W-1:0]  xl_ff, yl_ff;
   logic [SUM_W-1:0]         xa_in, ya_in;
   logic [LOC_W-1:0]         x_ff, y_ff;
   logic [LOC2_W-1:0]        x2_ff, y2_ff, x2b_ff, y2b_ff;
   logic [RAD2_W-1:0]        a2_ff, b2_ff, ab_ff;
   logic [PART_W-1:0]        pxh_ff, pxl_ff, pyh_ff, pyl_ff;
   logic [RAD4_W-1:0]        a4_ff, b4_ff, ab2_ff;
   logic [P_W-1:0]           p_ff, q_ff, n8_ff, n9_ff;
   logic [PART_W-1:0]        rxhh_ff, rxhl_ff, rxlh_ff, rxll_ff;
   logic [PART_W-1:0]        ryhh_ff, ryhl_ff, rylh_ff, ryll_ff;
   logic                     neg8_ff, neg9_ff;
   logic [RX_W-1:0]          rx_ff, ry_ff;
   logic [R_W-1:0]           r9_ff;

   always_comb begin
      xa_in = xl_ff[SUM_W-1] ? SUM_W'(-xl_ff) : SUM_W'(xl_ff);
      ya_in = yl_ff[SUM_W-1] ? SUM_W'(-yl_ff) : SUM_W'(yl_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= DIFF_W'(req_payload.point_x) - DIFF_W'(cx_ff);
         dy_ff   <= DIFF_W'(req_payload.point_y) - DIFF_W'(cy_ff);

         pcx_ff  <= PROD_W'(cos_w) * PROD_W'(dx_ff);
         psy_ff  <= PROD_W'(sin_w) * PROD_W'(dy_ff);
         pcy_ff  <= PROD_W'(cos_w) * PROD_W'(dy_ff);
         psx_ff  <= PROD_W'(sin_w) * PROD_W'(dx_ff);

         xl_ff   <= SUM_W'(pcx_ff) + SUM_W'(psy_ff);
         yl_ff   <= SUM_W'(pcy_ff) - SUM_W'(psx_ff);

         x_ff    <= LOC_W'((xa_in + RND_HALF) >> RND_SH);
         y_ff    <= LOC_W'((ya_in + RND_HALF) >> RND_SH);

         x2_ff   <= LOC2_W'(x_ff) * LOC2_W'(x_ff);
         y2_ff   <= LOC2_W'(y_ff) * LOC2_W'(y_ff);
         a2_ff   <= RAD2_W'(a_eff) * RAD2_W'(a_eff);
         b2_ff   <= RAD2_W'(b_eff) * RAD2_W'(b_eff);
         ab_ff   <= RAD2_W'(a_eff) * RAD2_W'(b_eff);

         pxh_ff  <= PART_W'(x2_ff[LOC2_W-1:LOC_W]) * PART_W'(b2_ff);
         pxl_ff  <= PART_W'(x2_ff[LOC_W-1:0]) * PART_W'(b2_ff);
         pyh_ff  <= PART_W'(y2_ff[LOC2_W-1:LOC_W]) * PART_W'(a2_ff);
         pyl_ff  <= PART_W'(y2_ff[LOC_W-1:0]) * PART_W'(a2_ff);
         a4_ff   <= RAD4_W'(a2_ff) * RAD4_W'(a2_ff);
         b4_ff   <= RAD4_W'(b2_ff) * RAD4_W'(b2_ff);
         ab2_ff  <= RAD4_W'(ab_ff) * RAD4_W'(ab_ff);
         x2b_ff  <= x2_ff;
         y2b_ff  <= y2_ff;

         p_ff    <= (P_W'(pxh_ff) << LOC_W) + P_W'(pxl_ff)
                  + (P_W'(pyh_ff) << LOC_W) + P_W'(pyl_ff);
         q_ff    <= P_W'(ab2_ff) << Q_SH;
         rxhh_ff <= PART_W'(x2b_ff[LOC2_W-1:LOC_W]) * PART_W'(b4_ff[RAD4_W-1:RAD2_W]);
         rxhl_ff <= PART_W'(x2b_ff[LOC2_W-1:LOC_W]) * PART_W'(b4_ff[RAD2_W-1:0]);
         rxlh_ff <= PART_W'(x2b_ff[LOC_W-1:0]) * PART_W'(b4_ff[RAD4_W-1:RAD2_W]);
         rxll_ff <= PART_W'(x2b_ff[LOC_W-1:0]) * PART_W'(b4_ff[RAD2_W-1:0]);
         ryhh_ff <= PART_W'(y2b_ff[LOC2_W-1:LOC_W]) * PART_W'(a4_ff[RAD4_W-1:RAD2_W]);
         ryhl_ff <= PART_W'(y2b_ff[LOC2_W-1:LOC_W]) * PART_W'(a4_ff[RAD2_W-1:0]);
         rylh_ff <= PART_W'(y2b_ff[LOC_W-1:0]) * PART_W'(a4_ff[RAD4_W-1:RAD2_W]);
         ryll_ff <= PART_W'(y2b_ff[LOC_W-1:0]) * PART_W'(a4_ff[RAD2_W-1:0]);

         neg8_ff <= p_ff < q_ff;
         n8_ff   <= (p_ff < q_ff) ? q_ff - p_ff : p_ff - q_ff;
         rx_ff   <= (RX_W'(rxhh_ff) << (LOC_W + RAD2_W)) + (RX_W'(rxhl_ff) << LOC_W)
                  + (RX_W'(rxlh_ff) << RAD2_W) + RX_W'(rxll_ff);
         ry_ff   <= (RX_W'(ryhh_ff) << (LOC_W + RAD2_W)) + (RX_W'(ryhl_ff) << LOC_W)
                  + (RX_W'(rylh_ff) << RAD2_W) + RX_W'(ryll_ff);

         r9_ff   <= R_W'(rx_ff) + R_W'(ry_ff);
         n9_ff   <= n8_ff;
         neg9_ff <= neg8_ff;
      end
   end

   // square root of the gradient term
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [P_W:0]      sq_side;

   erw_sqrt #(
      .RAD_W  (R_W),
      .ROOT_W (ROOT_W),
      .SIDE_W (P_W + 1)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v9_ff),
      .radicand  (r9_ff),
      .side_in   ({neg9_ff, n9_ff}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   logic [P_W-1:0]   n10_ff;
   logic [DVD_W-1:0] d10_ff;
   logic             neg10_ff, ovf10_ff, zero10_ff;
   logic [DVD_W-1:0] d_in;

   assign d_in = {sq_root, 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         n10_ff    <= sq_side[P_W-1:0];
         neg10_ff  <= sq_side[P_W];
         d10_ff    <= d_in;
         ovf10_ff  <= OVF_W'(sq_side[P_W-1:0]) >= (OVF_W'(d_in) << QUO_W);
         zero10_ff <= sq_root == '0;
      end
   end

   // residual division
   logic             rd_valid;
   logic [QUO_W-1:0] rd_quo;
   logic [2:0]       rd_side;

   erw_div #(
      .NUM_W  (P_W),
      .DEN_W  (DVD_W),
      .QUO_W  (QUO_W),
      .SIDE_W (3)
   ) u_res_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v10_ff),
      .num       (n10_ff),
      .den       (d10_ff),
      .side_in   ({neg10_ff, ovf10_ff, zero10_ff}),
      .out_valid (rd_valid),
      .quotient  (rd_quo),
      .side_out  (rd_side)
   );

   logic [RESIDUAL_WIDTH-1:0] capped_in, r_in, mag_in;
   logic [RESIDUAL_WIDTH-1:0] r11_ff, mag11_ff, r12_ff, mag12_ff;
   logic [T2_W-1:0]           t2_ff;
   logic [M2_W-1:0]           m2_ff;
   logic                      fix12_ff, tuk12_ff;
   logic [WEIGHT_WIDTH-1:0]   fw12_ff;
   logic                      fix_in, tuk_in;
   logic [WEIGHT_WIDTH-1:0]   fw_in;
   logic [WNUM_W-1:0]         wnum_ff;
   logic [T2_W-1:0]           wden_ff;
   logic [WSIDE_W-1:0]        wside_ff;

   always_comb begin
      capped_in = (rd_side[1] || rd_quo > RES_MAG_NEG) ? RES_MAG_NEG : rd_quo;
      if (rd_side[0]) begin
         r_in   = RES_MAG_NEG;
         mag_in = RES_MAG_NEG;
      end else if (rd_side[2]) begin
         r_in   = -capped_in;
         mag_in = capped_in;
      end else begin
         r_in   = (capped_in > RES_MAX_POS) ? RES_MAX_POS : capped_in;
         mag_in = r_in;
      end
   end

   always_comb begin
      tuk_in = 1'b0;
      unique case (mode_ff)
         LOSS_HUBER: begin
            fix_in = (thr_ff == '0) || (mag11_ff <= RESIDUAL_WIDTH'(thr_ff));
            fw_in  = WEIGHT_ONE;
         end
         LOSS_TUKEY: begin
            fix_in = (thr_ff == '0) || (mag11_ff > RESIDUAL_WIDTH'(thr_ff));
            fw_in  = '0;
            tuk_in = 1'b1;
         end
         default: begin
            fix_in = 1'b1;
            fw_in  = WEIGHT_ONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r11_ff   <= r_in;
         mag11_ff <= mag_in;

         t2_ff    <= T2_W'(thr_ff) * T2_W'(thr_ff);
         m2_ff    <= M2_W'(mag11_ff) * M2_W'(mag11_ff);
         r12_ff   <= r11_ff;
         mag12_ff <= mag11_ff;
         fix12_ff <= fix_in;
         fw12_ff  <= fw_in;
         tuk12_ff <= tuk_in;

         if (tuk12_ff) begin
            wnum_ff <= WNUM_W'(t2_ff - T2_W'(m2_ff)) << WEIGHT_FRAC_BITS;
            wden_ff <= t2_ff;
         end else begin
            wnum_ff <= WNUM_W'(thr_ff) << WEIGHT_FRAC_BITS;
            wden_ff <= T2_W'(mag12_ff);
         end
         wside_ff <= {r12_ff, fix12_ff, fw12_ff, tuk12_ff};
      end
   end

   // weight division
   logic                    wd_valid;
   logic [WEIGHT_WIDTH-1:0] wd_quo;
   logic [WSIDE_W-1:0]      wd_side;

   erw_div #(
      .NUM_W  (WNUM_W),
      .DEN_W  (T2_W),
      .QUO_W  (WEIGHT_WIDTH),
      .SIDE_W (WSIDE_W)
   ) u_wgt_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v13_ff),
      .num       (wnum_ff),
      .den       (wden_ff),
      .side_in   (wside_ff),
      .out_valid (wd_valid),
      .quotient  (wd_quo),
      .side_out  (wd_side)
   );

   logic [RESIDUAL_WIDTH-1:0] r14_ff;
   logic [WEIGHT_WIDTH-1:0]   w14_ff, w_in, floor_w;
   logic [UU_W-1:0]           uu;

   always_comb begin
      uu = UU_W'(wd_quo) * UU_W'(wd_quo);
      if (wd_side[WEIGHT_WIDTH+1]) begin
         w_in = wd_side[WEIGHT_WIDTH:1];
      end else if (wd_side[0]) begin
         w_in = WEIGHT_WIDTH'(uu >> WEIGHT_FRAC_BITS);
      end else begin
         w_in = wd_quo;
      end
      floor_w = (minw_ff > WEIGHT_ONE) ? WEIGHT_ONE : minw_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r14_ff <= wd_side[WSIDE_W-1:WEIGHT_WIDTH+2];
         w14_ff <= w_in;
         rsp_payload_ff.residual <= r14_ff;
         rsp_payload_ff.weight   <= (w14_ff < floor_w) ? floor_w : w14_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= sq_valid;
         v11_ff <= rd_valid;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= wd_valid;
         rsp_valid_ff <= v14_ff;
      end
   end

endmodule

`default_nettype wire

### src/erw_checker.sv
// ----------------------------------------------------------------------------
// erw_checker
// Port-level checks on the ellipse residual and weight core, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input erw_pkg::rsp_payload_type rsp_payload
);
   import erw_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // a stalled result blocks new points
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.weight <= WEIGHT_ONE)
      else $error("weight above one");

   // drop results across reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind ellipse_residual_weight_core erw_checker u_erw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### dv/ellipse_residual_weight_core_test.sv
// ----------------------------------------------------------------------------
// ellipse_residual_weight_core_test
// Streams edge points through the core under a series of ellipse and loss
// settings and checks residual and weight of every result beat against a
// bit-exact predictor kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_residual_weight_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import erw_pkg::*;

   localparam logic [1:0] LOSS_SPARE = 2'd3;
   localparam int         CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_CENTER_X;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic signed [15:0] ell_cx = '0, ell_cy = '0;
   logic [14:0] ell_ra = RADIUS_RESET, ell_rb = RADIUS_RESET;
   logic [31:0] ell_rot = ROTATION_RESET;
   logic [1:0]  ell_mode = LOSS_NONE;
   logic [22:0] ell_thr = '0;
   logic [15:0] ell_floor = '0;

   rsp_payload_type fit_fifo [4096];
   logic [11:0] fit_wr = '0;
   logic [11:0] fit_rd = '0;
   int  mismatches = 0;
   int  cycles = 0;
   bit  steady = 1'b0;
   int  stall_left = 0;

   ellipse_residual_weight_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("ellipse_residual_weight_core_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic rsp_payload_type fit_point(logic signed [15:0] px,
                                                 logic signed [15:0] py);
      longint dx, dy, cs, sn, vx, vy, res;
      logic [127:0] xm, ym, a, b, p, q, n, r, root, cand, quo, mag, w, u, t2;
      logic neg;
      rsp_payload_type fit;
      dx = longint'(px) - longint'(ell_cx);
      dy = longint'(py) - longint'(ell_cy);
      cs = longint'($signed(ell_rot[15:0]));
      sn = longint'($signed(ell_rot[31:16]));
      vx = cs * dx + sn * dy;
      vy = cs * dy - sn * dx;
      xm = 128'(((vx < 0) ? -vx : vx) + 512) >> 10;
      ym = 128'(((vy < 0) ? -vy : vy) + 512) >> 10;
      a = (ell_ra == 0) ? 128'd1 : 128'(ell_ra);
      b = (ell_rb == 0) ? 128'd1 : 128'(ell_rb);
      p = (xm * b) * (xm * b) + (ym * a) * (ym * a);
      q = ((a * b) * (a * b)) << 8;
      neg = p < q;
      n = neg ? q - p : p - q;
      r = (xm * b * b) * (xm * b * b) + (ym * a * a) * (ym * a * a);
      if (r == 0) begin
         res = -longint'(RES_MAG_NEG);
      end else begin
         root = '0;
         for (int k = 63; k >= 0; k--) begin
            cand = root | (128'd1 << k);
            if (cand * cand <= r) root = cand;
         end
         quo = n / (2 * root);
         if (neg) res = -longint'((quo > RES_MAG_NEG) ? 128'(RES_MAG_NEG) : quo);
         else     res = longint'((quo > RES_MAX_POS) ? 128'(RES_MAX_POS) : quo);
      end
      mag = 128'((res < 0) ? -res : res);
      if (ell_mode == LOSS_HUBER) begin
         if (ell_thr == 0 || mag <= ell_thr) w = WEIGHT_ONE;
         else w = (128'(ell_thr) * WEIGHT_ONE) / mag;
         if (w > WEIGHT_ONE) w = WEIGHT_ONE;
      end else if (ell_mode == LOSS_TUKEY) begin
         if (ell_thr == 0 || mag > ell_thr) begin
            w = '0;
         end else begin
            t2 = 128'(ell_thr) * 128'(ell_thr);
            u  = ((t2 - mag * mag) * WEIGHT_ONE) / t2;
            w  = (u * u) >> WEIGHT_FRAC_BITS;
         end
      end else begin
         w = WEIGHT_ONE;
      end
      if (w < ((ell_floor > WEIGHT_ONE) ? WEIGHT_ONE : ell_floor))
         w = (ell_floor > WEIGHT_ONE) ? WEIGHT_ONE : ell_floor;
      fit.residual = RESIDUAL_WIDTH'(res);
      fit.weight   = WEIGHT_WIDTH'(w);
      return fit;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fit_wr == fit_rd) begin
            report_mismatch("unexpected beat residual", 0, rsp_payload.residual);
         end else begin
            want = fit_fifo[fit_rd];
            fit_rd = fit_rd + 12'd1;
            if (want.residual !== rsp_payload.residual)
               report_mismatch("residual", want.residual, rsp_payload.residual);
            if (want.weight !== rsp_payload.weight)
               report_mismatch("weight", want.weight, rsp_payload.weight);
         end
      end
   end

   task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
      int gap;
      if (!steady && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.point_x <= px;
      req_payload.point_y <= py;
      fit_fifo[fit_wr] = fit_point(px, py);
      fit_wr = fit_wr + 12'd1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (fit_wr != fit_rd) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CENTER_X:       ell_cx    = value[15:0];
         CSR_CENTER_Y:       ell_cy    = value[15:0];
         CSR_RADIUS_MAJOR:   ell_ra    = value[14:0];
         CSR_RADIUS_MINOR:   ell_rb    = value[14:0];
         CSR_ROTATION:       ell_rot   = value;
         CSR_LOSS_MODE:      ell_mode  = value[1:0];
         CSR_LOSS_THRESHOLD: ell_thr   = value[22:0];
         CSR_MIN_WEIGHT:     ell_floor = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_ellipse(logic [15:0] cx, logic [15:0] cy, logic [14:0] ra,
                              logic [14:0] rb, logic [31:0] rot);
      write_reg(CSR_CENTER_X, 32'(cx));
      write_reg(CSR_CENTER_Y, 32'(cy));
      write_reg(CSR_RADIUS_MAJOR, 32'(ra));
      write_reg(CSR_RADIUS_MINOR, 32'(rb));
      write_reg(CSR_ROTATION, rot);
   endtask

   task automatic set_loss(logic [1:0] mode, logic [22:0] thr, logic [15:0] floor_w);
      write_reg(CSR_LOSS_MODE, 32'(mode));
      write_reg(CSR_LOSS_THRESHOLD, 32'(thr));
      write_reg(CSR_MIN_WEIGHT, 32'(floor_w));
   endtask

   // point near the unrotated outline of the current ellipse, about its centre
   task automatic send_near_outline();
      int ox, oy;
      ox = $urandom_range(0, 2 * ell_ra + 32) - ell_ra - 16;
      oy = $urandom_range(0, 2 * ell_rb + 32) - ell_rb - 16;
      if ($urandom_range(0, 1)) ox = (ox < 0) ? -ell_ra + oy % 17 : ell_ra + oy % 17;
      else                      oy = (oy < 0) ? -ell_rb + ox % 17 : ell_rb + ox % 17;
      send_point(16'(ell_cx + ox), 16'(ell_cy + oy));
   endtask

   task automatic test_reset_values();
      send_point(16'sd0, 16'sd0);
      send_point(16'sd16, 16'sd0);
      send_point(16'sd0, -16'sd16);
      send_point(16'sh7fff, 16'sh7fff);
      send_point(-16'sh8000, -16'sh8000);
      send_point(16'sh7fff, -16'sh8000);
   endtask

   task automatic test_extremes();
      set_ellipse(16'h8000, 16'h7fff, 15'd0, 15'h7fff, 32'h8000_7fff);
      set_loss(LOSS_SPARE, 23'h7fffff, 16'hffff);
      send_point(16'sh7fff, -16'sh8000);
      send_point(-16'sh8000, 16'sh7fff);
      send_point(-16'sh8000, 16'sh7fff);
      set_ellipse(16'h0, 16'h0, 15'h7fff, 15'd0, 32'h7fff_8000);
      set_loss(LOSS_NONE, 23'd0, 16'd32768);
      send_point(16'sh1234, -16'sh4321);
      send_point(16'sd0, 16'sd0);
   endtask

   task automatic test_huber();
      set_ellipse(16'd160, -16'sd80, 15'd800, 15'd320, {16'd11585, 16'd11585});
      set_loss(LOSS_HUBER, 23'd0, 16'd0);
      send_point(16'sd900, 16'sd700);
      write_reg(CSR_LOSS_THRESHOLD, 32'd512);
      send_point(16'sd160, -16'sd80);
      send_point(16'sd760, 16'sd480);
      send_point(16'sd300, -16'sd80);
      send_point(16'sh7fff, 16'sh7fff);
   endtask

   task automatic test_tukey();
      set_loss(LOSS_TUKEY, 23'd0, 16'd0);
      send_point(16'sd700, 16'sd500);
      write_reg(CSR_LOSS_THRESHOLD, 32'd4096);
      send_point(16'sd720, 16'sd500);
      send_point(16'sd165, -16'sd80);
      send_point(16'sh7fff, 16'sh7fff);
      write_reg(CSR_MIN_WEIGHT, 32'd9000);
      send_point(16'sh7fff, 16'sh7fff);
      send_point(16'sd720, 16'sd500);
   endtask

   task automatic test_random_fits();
      for (int n = 0; n < 1250; ) begin
         if (n > 1000) steady = 1'b1;
         if ($urandom_range(0, 3) == 0)
            set_ellipse(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                        $urandom);
         else
            set_ellipse(16'($urandom_range(0, 4000) - 2000),
                        16'($urandom_range(0, 4000) - 2000),
                        15'($urandom_range(16, 3000)), 15'($urandom_range(16, 3000)),
                        {16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 32768) - 16384)});
         set_loss(2'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 8192)),
                  ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom));
         for (int k = $urandom_range(40, 120); k > 0; k--, n++) begin
            if ($urandom_range(0, 4) == 0) send_point(16'($urandom), 16'($urandom));
            else send_near_outline();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_extremes();
      test_huber();
      test_tukey();
      test_random_fits();
      req_valid <= 1'b0;
      while (fit_wr != fit_rd) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("ellipse_residual_weight_core_test: PASS");
      else $display("ellipse_residual_weight_core_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

### ellipse_residual_weight_core.f
src/erw_pkg.sv
src/erw_div.sv
src/erw_sqrt.sv
src/ellipse_residual_weight_core.sv
src/erw_checker.sv
dv/ellipse_residual_weight_core_test.sv
